// ===== rtl/core/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell layout, operation codes and the screen store port
// bundle shared by the console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Fixed field widths of the beats.
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W = 1;

  // Character codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // Operation codes.
  localparam logic [KIND_W-1:0] K_PUT          = 3'd0;
  localparam logic [KIND_W-1:0] K_BACKSPACE    = 3'd1;
  localparam logic [KIND_W-1:0] K_CLEAR_SCREEN = 3'd2;
  localparam logic [KIND_W-1:0] K_CLEAR_LINE   = 3'd3;
  localparam logic [KIND_W-1:0] K_SET_CURSOR   = 3'd4;
  localparam logic [KIND_W-1:0] K_RECOLOUR     = 3'd5;
  localparam logic [KIND_W-1:0] K_READ_CELL    = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE = 1'd1;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Request bundle from the sequencer to the screen store.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } tcw_mem_req_t;

  // Linear cell index of a screen position.
  function automatic addr_t lin_index(input logic [ROW_W-1:0] r,
                                      input logic [COL_W-1:0] c);
    lin_index = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tcw_screen_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console screen store
// Single write port, single read port cell memory with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_store (
  input  wire                  clk,
  input  wire tcw_pkg::tcw_mem_req_t req,
  output tcw_pkg::cell_t        rdata
);
  import tcw_pkg::*;

  cell_t mem [CELL_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcw_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console sequencer
// Decodes each operation, keeps the cursor, and walks the screen store with
// one shared address counter for fills, scrolls and recolours.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [tcw_pkg::KIND_W-1:0]    kind,
  input  wire [tcw_pkg::CHAR_W-1:0]    char_code,
  input  wire [tcw_pkg::COL_W-1:0]     col,
  input  wire [tcw_pkg::ROW_W-1:0]     row,
  input  wire [tcw_pkg::ATTR_W-1:0]    text_color,
  input  wire                          scroll_enable,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::IDX_W-1:0]    cursor_index,
  output tcw_pkg::tcw_mem_req_t        mem_req,
  input  wire tcw_pkg::cell_t          mem_rdata
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [2:0]        state;
  logic [KIND_W-1:0] op_kind;
  logic [CHAR_W-1:0] op_char;
  logic [COL_W-1:0]  op_col;
  logic [ROW_W-1:0]  op_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  addr_t             idx;
  addr_t             last;
  addr_t             rd_off;
  addr_t             wr_addr;
  logic              wr_pend;
  logic              recolour;
  logic              scroll_phase;
  logic              quiet;
  cell_t             fill_cell;
  cell_t             cell_rd;

  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  addr_t             lin_res;
  logic              put_nl;
  logic              line_end;
  logic              past_last;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              read_in_range;
  cell_t             copy_data;
  cell_t             blank_cell;

  assign in_ready = (state == S_IDLE);
  assign blank_cell = {text_color, SPACE_CODE};

  // Shared index unit: one row-times-columns-plus-column calculation.
  always_comb begin
    sel_row = cur_row;
    sel_col = cur_col;
    if (state == S_EXEC && op_kind == K_CLEAR_LINE) begin
      sel_row = op_row;
      sel_col = '0;
    end else if (state == S_EXEC && op_kind == K_READ_CELL) begin
      sel_row = op_row;
      sel_col = op_col;
    end
    lin_res = lin_index(sel_row, sel_col);
  end

  // Cursor movement for a put character or newline.
  always_comb begin
    put_nl    = (op_char == NEWLINE_CODE);
    line_end  = put_nl || (cur_col == LAST_COL);
    past_last = line_end && (cur_row == LAST_ROW);
    put_col   = line_end ? '0 : cur_col + 1'b1;
    put_row   = (line_end && !past_last) ? cur_row + 1'b1 : cur_row;
  end

  assign read_in_range = (op_col <= LAST_COL) && (op_row <= LAST_ROW);
  assign copy_data = recolour ? {text_color, mem_rdata[CHAR_W-1:0]} : mem_rdata;

  // Screen store requests.
  always_comb begin
    mem_req = '0;
    case (state)
      S_EXEC: begin
        if (op_kind == K_PUT && !put_nl) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = lin_res;
          mem_req.wdata = {text_color, op_char};
        end
        if (op_kind == K_READ_CELL && read_in_range) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = lin_res;
        end
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx;
        mem_req.wdata = fill_cell;
      end
      S_COPY: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx + rd_off;
        mem_req.we    = wr_pend;
        mem_req.waddr = wr_addr;
        mem_req.wdata = copy_data;
      end
      S_TAIL: begin
        mem_req.we    = wr_pend;
        mem_req.waddr = wr_addr;
        mem_req.wdata = copy_data;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Sequencer. Reset starts with a clearing pass over the whole store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      idx          <= '0;
      last         <= ADDR_W'(CELL_COUNT - 1);
      fill_cell    <= {RESET_ATTR, SPACE_CODE};
      quiet        <= 1'b1;
      out_valid    <= 1'b0;
      cur_col      <= '0;
      cur_row      <= '0;
      wr_pend      <= 1'b0;
      recolour     <= 1'b0;
      scroll_phase <= 1'b0;
    end else begin
      // Once out_ready takes the result, the output register empties unless a new result is loaded this cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind <= kind;
            op_char <= char_code;
            op_col  <= col;
            op_row  <= row;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          cell_rd <= '0;
          quiet   <= 1'b0;
          case (op_kind)
            K_PUT: begin
              cur_col <= put_col;
              cur_row <= put_row;
              if (past_last && scroll_enable) begin
                idx          <= '0;
                last         <= ADDR_W'(CELL_COUNT - COLUMNS - 1);
                rd_off       <= ADDR_W'(COLUMNS);
                recolour     <= 1'b0;
                scroll_phase <= 1'b1;
                state        <= S_COPY;
              end else begin
                state <= S_DONE;
              end
            end
            K_BACKSPACE: begin
              state <= S_DONE;
              if (cur_col != '0) begin
                cur_col <= cur_col - 1'b1;
              end else if (cur_row != '0) begin
                cur_row <= cur_row - 1'b1;
                cur_col <= LAST_COL;
              end
            end
            K_CLEAR_SCREEN: begin
              idx       <= '0;
              last      <= ADDR_W'(CELL_COUNT - 1);
              fill_cell <= blank_cell;
              cur_col   <= '0;
              cur_row   <= '0;
              state     <= S_FILL;
            end
            K_CLEAR_LINE: begin
              if (op_row <= LAST_ROW) begin
                idx       <= lin_res;
                last      <= lin_res + ADDR_W'(COLUMNS - 1);
                fill_cell <= blank_cell;
                state     <= S_FILL;
              end else begin
                state <= S_DONE;
              end
            end
            K_SET_CURSOR: begin
              cur_col <= (op_col <= LAST_COL) ? op_col : LAST_COL;
              cur_row <= (op_row <= LAST_ROW) ? op_row : LAST_ROW;
              state   <= S_DONE;
            end
            K_RECOLOUR: begin
              idx          <= '0;
              last         <= ADDR_W'(CELL_COUNT - 1);
              rd_off       <= '0;
              recolour     <= 1'b1;
              scroll_phase <= 1'b0;
              state        <= S_COPY;
            end
            K_READ_CELL: begin
              if (read_in_range) begin
                state <= S_READ;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_FILL: begin
          idx <= idx + 1'b1;
          if (idx == last) begin
            state <= quiet ? S_IDLE : S_DONE;
          end
        end
        S_COPY: begin
          // Read runs one cell ahead of the write of the cell read before.
          wr_pend <= 1'b1;
          wr_addr <= idx;
          idx     <= idx + 1'b1;
          if (idx == last) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          wr_pend <= 1'b0;
          if (scroll_phase) begin
            idx          <= ADDR_W'(CELL_COUNT - COLUMNS);
            last         <= ADDR_W'(CELL_COUNT - 1);
            fill_cell    <= blank_cell;
            scroll_phase <= 1'b0;
            state        <= S_FILL;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          cell_rd <= mem_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            cell_data    <= cell_rd;
            cursor_col   <= cur_col;
            cursor_row   <= cur_row;
            cursor_index <= IDX_W'(lin_res);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/text_console_writer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console engine with cursor, scrolling, clears, recolour and
// cell read-back over a single-port-pair screen store.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   kind, char_code, col, row
// out      output     out_valid / out_ready cell_data, cursor_col, cursor_row,
//                                           cursor_index
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// Cursor moves, set cursor, reads and plain characters need no walk. Clear
// line walks the COLUMNS cells of its row, clear screen and recolour all
// CELL_COUNT cells, and a scroll copies rows up and blanks the last row, at
// one cell per cycle of the address counter over the screen store. After
// reset a clearing pass over all CELL_COUNT cells runs with in_ready low. The
// sequencer holds a finished result until the output register is free.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [tcw_pkg::KIND_W-1:0]      kind,
  input  wire [tcw_pkg::CHAR_W-1:0]      char_code,
  input  wire [tcw_pkg::COL_W-1:0]       col,
  input  wire [tcw_pkg::ROW_W-1:0]       row,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::IDX_W-1:0]      cursor_index,
  input  wire                            cfg_we,
  input  wire [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_color;
  logic              scroll_enable;
  tcw_mem_req_t      mem_req;
  cell_t             mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color    <= RESET_ATTR;
      scroll_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLOR:    text_color    <= cfg_wdata;
        CFG_SCROLL_ENABLE: scroll_enable <= cfg_wdata[0];
        default: begin
          text_color <= text_color;
        end
      endcase
    end
  end

  // Operation sequencer.
  tcw_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .char_code     (char_code),
    .col           (col),
    .row           (row),
    .text_color    (text_color),
    .scroll_enable (scroll_enable),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_data     (cell_data),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_index  (cursor_index),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // Screen store.
  tcw_screen_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
